>>> sv/lms_pkg.sv
package lms_pkg;

    localparam int SIDE = 16;
    localparam int XY_W = $clog2(SIDE);
    localparam int ADDR_W = 2 * XY_W;
    localparam int LEVEL_W = 7;
    localparam int WORD_W = 32;
    localparam int SCALE_W = 14;
    localparam int THRESH_W = 20;
    localparam int PROD_W = 21;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
    localparam logic [LEVEL_W-1:0] PHASE_MAX = 7'd99;
    localparam logic [THRESH_W-1:0] PHASE_WEIGHT = 20'd10000;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_ROTATION = 2'd0;
    localparam logic [1:0] CFG_GLOBAL = 2'd1;
    localparam logic [1:0] CFG_FLOOR = 2'd2;
    localparam logic [1:0] CFG_CEILING = 2'd3;

    typedef enum logic [1:0] {
        FUNC_SET = 2'd0,
        FUNC_RECT = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_REFRESH = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETW,
        ST_RECT,
        ST_CLR,
        ST_ACK,
        ST_ERR,
        ST_REF_SETUP,
        ST_REF_READ,
        ST_REF_DRAIN,
        ST_REF_EMIT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic set_wr;
        logic rect_wr;
        logic clear;
        logic ref_setup;
        logic rd_issue;
        logic emit_word;
        logic emit_ack;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic rect_done;
        logic lim_bad;
        logic j_last;
        logic i_last;
        logic out_free;
    } t_sts;

    // Pin bit of each scanned column
    localparam logic [WORD_W-1:0] COL_PIN [SIDE] = '{
        32'h00001000, 32'h10000000, 32'h00080000, 32'h00000200,
        32'h08000000, 32'h00000400, 32'h00000800, 32'h00000100,
        32'h00000020, 32'h40000000, 32'h80000000, 32'h00000008,
        32'h20000000, 32'h00000004, 32'h00000080, 32'h00000001
    };

    // Pin bit of each row
    localparam logic [WORD_W-1:0] ROW_PIN [SIDE] = '{
        32'h00000010, 32'h00000040, 32'h00004000, 32'h00000002,
        32'h00002000, 32'h00008000, 32'h04000000, 32'h02000000,
        32'h00020000, 32'h00010000, 32'h00800000, 32'h00040000,
        32'h00200000, 32'h00400000, 32'h01000000, 32'h00100000
    };

endpackage

>>> sv/lms_ctrl.sv
module lms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_func,
    input  lms_pkg::t_sts i_sts,
    output lms_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import lms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_func'(i_func))
                        FUNC_SET:     n_state = ST_SETW;
                        FUNC_RECT:    n_state = ST_RECT;
                        FUNC_CLEAR:   n_state = ST_CLR;
                        FUNC_REFRESH: n_state = ST_REF_SETUP;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SETW:      n_state = ST_ACK;
            ST_CLR:       n_state = ST_ACK;
            ST_RECT:      if (i_sts.rect_done) n_state = ST_ACK;
            ST_ACK:       if (i_sts.out_free) n_state = ST_IDLE;
            ST_ERR:       if (i_sts.out_free) n_state = ST_IDLE;
            ST_REF_SETUP: n_state = i_sts.lim_bad ? ST_ERR : ST_REF_READ;
            ST_REF_READ:  if (i_sts.j_last) n_state = ST_REF_DRAIN;
            ST_REF_DRAIN: n_state = ST_REF_EMIT;
            ST_REF_EMIT: begin
                if (i_sts.out_free) n_state = i_sts.i_last ? ST_IDLE : ST_REF_READ;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            ST_SETW:      o_cmd.set_wr = 1'b1;
            ST_RECT:      o_cmd.rect_wr = 1'b1;
            ST_CLR:       o_cmd.clear = 1'b1;
            ST_ACK:       o_cmd.emit_ack = i_sts.out_free;
            ST_ERR:       o_cmd.emit_err = i_sts.out_free;
            ST_REF_SETUP: o_cmd.ref_setup = 1'b1;
            ST_REF_READ:  o_cmd.rd_issue = 1'b1;
            ST_REF_DRAIN: o_cmd = '0;
            ST_REF_EMIT:  o_cmd.emit_word = i_sts.out_free;
            default:      o_cmd = '0;
        endcase
    end

endmodule

>>> sv/lms_datapath.sv
module lms_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lms_pkg::t_cmd                 i_cmd,
    output lms_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    input  logic [lms_pkg::XY_W-1:0]      i_x_first,
    input  logic [lms_pkg::XY_W-1:0]      i_y_first,
    input  logic [lms_pkg::XY_W-1:0]      i_x_second,
    input  logic [lms_pkg::XY_W-1:0]      i_y_second,
    input  logic                          i_fill,
    input  logic                          i_pixel_on,
    input  logic [lms_pkg::LEVEL_W-1:0]   i_pixel_level,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [lms_pkg::WORD_W-1:0]    o_column_word,
    output logic [lms_pkg::XY_W-1:0]      o_column_index,
    output logic                          o_last,
    output logic                          o_status
);
    import lms_pkg::*;

    localparam int CELLS = SIDE * SIDE;

    // Configuration registers
    logic [1:0]         r_rot;
    logic [LEVEL_W-1:0] r_global;
    logic [LEVEL_W-1:0] r_floor;
    logic [7:0]         r_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= 2'd0;
            r_global <= LEVEL_FULL;
            r_floor <= '0;
            r_ceil <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROTATION: r_rot <= i_cfg_data[1:0];
                CFG_GLOBAL:   r_global <= i_cfg_data[LEVEL_W-1:0];
                CFG_FLOOR:    r_floor <= i_cfg_data[LEVEL_W-1:0];
                CFG_CEILING:  r_ceil <= i_cfg_data;
                default:      r_ceil <= r_ceil;
            endcase
        end
    end

    // Limits and brightness scale
    logic [LEVEL_W-1:0] w_hi;
    logic [SCALE_W-1:0] w_scale;
    logic               w_lim_bad;

    assign w_hi = (r_ceil == 8'd0 || r_ceil > {1'b0, LEVEL_FULL}) ? LEVEL_FULL
                                                                  : r_ceil[LEVEL_W-1:0];
    assign w_lim_bad = r_floor >= w_hi;
    assign w_scale = SCALE_W'(SCALE_W'(w_hi - r_floor) * SCALE_W'(r_global)
                              + SCALE_W'(r_floor) * SCALE_W'(LEVEL_FULL));

    // Latched item
    logic [XY_W-1:0]    r_x, r_y, r_xlo, r_xhi, r_ylo, r_yhi, r_cx, r_cy;
    logic               r_fill, r_on;
    logic [LEVEL_W-1:0] r_lvl;
    logic [XY_W-1:0]    w_xlo, w_xhi, w_ylo, w_yhi;

    assign w_xlo = (i_x_first > i_x_second) ? i_x_second : i_x_first;
    assign w_xhi = (i_x_first > i_x_second) ? i_x_first : i_x_second;
    assign w_ylo = (i_y_first > i_y_second) ? i_y_second : i_y_first;
    assign w_yhi = (i_y_first > i_y_second) ? i_y_first : i_y_second;

    logic w_rect_done;
    assign w_rect_done = (r_cx == r_xhi) && (r_cy == r_yhi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x <= i_x_first;
            r_y <= i_y_first;
            r_fill <= i_fill;
            r_on <= i_pixel_on;
            r_lvl <= i_pixel_level;
            r_xlo <= w_xlo;
            r_xhi <= w_xhi;
            r_ylo <= w_ylo;
            r_yhi <= w_yhi;
            r_cx <= w_xlo;
            r_cy <= w_ylo;
        end else if (i_cmd.rect_wr && !w_rect_done) begin
            if (r_cy == r_yhi) begin
                r_cy <= r_ylo;
                r_cx <= r_cx + 1'b1;
            end else begin
                r_cy <= r_cy + 1'b1;
            end
        end
    end

    // Scan counters, phase and per-refresh constants
    logic [XY_W-1:0]     r_i, r_j;
    logic [LEVEL_W-1:0]  r_phase;
    logic [SCALE_W-1:0]  r_scale;
    logic [THRESH_W-1:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_i <= '0;
            r_j <= '0;
        end else begin
            if (i_cmd.ref_setup) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (i_cmd.rd_issue) r_j <= r_j + 1'b1;
            if (i_cmd.emit_word) begin
                r_i <= r_i + 1'b1;
                if (r_i == XY_W'(SIDE - 1)) begin
                    r_phase <= (r_phase >= PHASE_MAX) ? '0 : r_phase + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ref_setup) begin
            r_scale <= w_scale;
            r_thresh <= THRESH_W'((THRESH_W'(r_phase) + 1'b1) * PHASE_WEIGHT);
        end
    end

    // Pixel store: one valid bit per pixel marks it written since the last clear
    logic [LEVEL_W-1:0] r_lvl_mem [CELLS];
    logic               r_flag_mem [CELLS];
    logic [CELLS-1:0]   r_valid;
    logic [ADDR_W-1:0]  w_wr_addr, w_rd_addr;
    logic               w_rect_hit, w_flag_we, w_wr_valid, w_lvl_we;
    logic [XY_W-1:0]    w_sc, w_sr;

    assign w_rect_hit = r_fill || r_cx == r_xlo || r_cx == r_xhi
                        || r_cy == r_ylo || r_cy == r_yhi;
    assign w_flag_we = i_cmd.set_wr || (i_cmd.rect_wr && w_rect_hit);
    assign w_wr_addr = i_cmd.set_wr ? {r_x, r_y} : {r_cx, r_cy};
    assign w_wr_valid = r_valid[w_wr_addr];
    // A rectangle on a cleared pixel also stores the cleared level
    assign w_lvl_we = i_cmd.set_wr || (w_flag_we && !w_wr_valid);

    // Scan position to stored pixel through the rotation
    always_comb begin
        case (r_rot)
            2'd1:    begin w_sc = r_j;  w_sr = ~r_i; end
            2'd2:    begin w_sc = ~r_i; w_sr = ~r_j; end
            2'd3:    begin w_sc = ~r_j; w_sr = r_i;  end
            default: begin w_sc = r_i;  w_sr = r_j;  end
        endcase
    end
    assign w_rd_addr = {w_sc, w_sr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= '0;
        end else if (w_flag_we) begin
            r_valid[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lvl_we) r_lvl_mem[w_wr_addr] <= i_cmd.set_wr ? r_lvl : LEVEL_FULL;
        if (w_flag_we) r_flag_mem[w_wr_addr] <= i_cmd.set_wr ? r_on : 1'b1;
    end

    // Read stage
    logic [LEVEL_W-1:0] r_rd_lvl;
    logic               r_rd_flag, r_rd_v, r_b_valid;
    logic [XY_W-1:0]    r_b_j;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_lvl <= r_lvl_mem[w_rd_addr];
            r_rd_flag <= r_flag_mem[w_rd_addr];
            r_rd_v <= r_valid[w_rd_addr];
            r_b_j <= r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_cmd.rd_issue;
        end
    end

    // Lit test: phase < floor(p/10000)  <=>  (phase+1)*10000 <= p
    logic [LEVEL_W-1:0] w_px_lvl;
    logic               w_px_on, w_lit;
    logic [PROD_W-1:0]  w_prod;

    assign w_px_lvl = r_rd_v ? r_rd_lvl : LEVEL_FULL;
    assign w_px_on = r_rd_v && r_rd_flag;
    assign w_prod = PROD_W'(PROD_W'(w_px_lvl) * PROD_W'(r_scale));
    assign w_lit = w_px_on && (r_global != '0) && (w_prod >= PROD_W'(r_thresh));

    // Row pin accumulator for the current column
    logic [WORD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ref_setup || i_cmd.emit_word) begin
            r_acc <= '0;
        end else if (r_b_valid && !w_lit) begin
            r_acc <= r_acc | ROW_PIN[r_b_j];
        end
    end

    // Output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [XY_W-1:0]   r_out_idx;
    logic              r_out_last, r_out_status;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_word || i_cmd.emit_ack || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_word) begin
            r_out_word <= COL_PIN[r_i] | r_acc;
            r_out_idx <= r_i;
            r_out_last <= (r_i == XY_W'(SIDE - 1));
            r_out_status <= 1'b0;
        end else if (i_cmd.emit_ack || i_cmd.emit_err) begin
            r_out_word <= '0;
            r_out_idx <= '0;
            r_out_last <= 1'b1;
            r_out_status <= i_cmd.emit_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_column_word = r_out_word;
    assign o_column_index = r_out_idx;
    assign o_last = r_out_last;
    assign o_status = r_out_status;

    assign o_sts.rect_done = w_rect_done;
    assign o_sts.lim_bad = w_lim_bad;
    assign o_sts.j_last = (r_j == XY_W'(SIDE - 1));
    assign o_sts.i_last = (r_i == XY_W'(SIDE - 1));
    assign o_sts.out_free = w_out_free;

    a_emit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.emit_word, i_cmd.emit_ack, i_cmd.emit_err}))
        else $error("more than one result loaded at once");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_word || i_cmd.emit_ack || i_cmd.emit_err) |-> w_out_free)
        else $error("result loaded over a held word");

    a_no_rw_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.set_wr || i_cmd.rect_wr || i_cmd.clear) |-> !i_cmd.rd_issue)
        else $error("store written during a scan read");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_word |-> !r_b_valid)
        else $error("column word emitted before last pixel accumulated");

endmodule

>>> sv/led_matrix_scan_controller.sv
// Set pixel and clear: one write, then the result; rectangle: a write step for each pixel
// of its bounding box, then the result.
// Refresh: 16 columns, each 16 reads of the single-port pixel store plus drain and
// load of the column word, which waits while the output still holds a stalled word.
// Invalid limits give one status result after the setup state. One item at a time.
// Reset (synchronous, active low) clears the store to off at level 100, phase to 0.
module led_matrix_scan_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_func,
    input  logic [lms_pkg::XY_W-1:0]    i_x_first,
    input  logic [lms_pkg::XY_W-1:0]    i_y_first,
    input  logic [lms_pkg::XY_W-1:0]    i_x_second,
    input  logic [lms_pkg::XY_W-1:0]    i_y_second,
    input  logic                        i_fill,
    input  logic                        i_pixel_on,
    input  logic [lms_pkg::LEVEL_W-1:0] i_pixel_level,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lms_pkg::WORD_W-1:0]  o_column_word,
    output logic [lms_pkg::XY_W-1:0]    o_column_index,
    output logic                        o_last,
    output logic                        o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);
    import lms_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    lms_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_x_first      (i_x_first),
        .i_y_first      (i_y_first),
        .i_x_second     (i_x_second),
        .i_y_second     (i_y_second),
        .i_fill         (i_fill),
        .i_pixel_on     (i_pixel_on),
        .i_pixel_level  (i_pixel_level),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_column_word  (o_column_word),
        .o_column_index (o_column_index),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lms_pkg::*;

    typedef struct packed {
        logic [1:0]         func;
        logic [XY_W-1:0]    x1;
        logic [XY_W-1:0]    y1;
        logic [XY_W-1:0]    x2;
        logic [XY_W-1:0]    y2;
        logic               fill;
        logic               on;
        logic [LEVEL_W-1:0] lvl;
    } t_cmd_word;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [XY_W-1:0]   col;
        logic              last;
        logic              status;
    } t_col_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_func = '0;
    logic [XY_W-1:0] i_x_first = '0, i_y_first = '0, i_x_second = '0, i_y_second = '0;
    logic i_fill = 1'b0, i_pixel_on = 1'b0;
    logic [LEVEL_W-1:0] i_pixel_level = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [WORD_W-1:0] o_column_word;
    logic [XY_W-1:0] o_column_index;
    logic o_last, o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    led_matrix_scan_controller i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow of the block state
    logic [1:0] m_rot;
    logic [7:0] m_global, m_floor, m_ceil;
    logic m_flag [SIDE*SIDE];
    logic [LEVEL_W-1:0] m_level [SIDE*SIDE];
    logic [LEVEL_W-1:0] m_phase;

    t_cmd_word pending_cmds[$];
    t_col_word expected_cols[$];
    int errors = 0;
    bit quiet = 0;       // no idling stretch
    bit in_fire = 0;     // input word taken at the last rising edge

    function automatic int pix(int x, int y);
        return (x % SIDE) * SIDE + (y % SIDE);
    endfunction

    task automatic push_ack(logic st);
        t_col_word w;
        w = '0;
        w.last = 1'b1;
        w.status = st;
        expected_cols.push_back(w);
    endtask

    // Apply one accepted command and queue the words it produces
    task automatic predict_scan(t_cmd_word c);
        int xa, xb, ya, yb, hi, lo, scale, duty, sc, sr, p;
        t_col_word w;
        case (t_func'(c.func))
            FUNC_SET: begin
                m_flag[pix(c.x1, c.y1)] = c.on;
                m_level[pix(c.x1, c.y1)] = c.lvl;
                push_ack(1'b0);
            end
            FUNC_RECT: begin
                xa = (c.x1 < c.x2) ? c.x1 : c.x2;
                xb = (c.x1 < c.x2) ? c.x2 : c.x1;
                ya = (c.y1 < c.y2) ? c.y1 : c.y2;
                yb = (c.y1 < c.y2) ? c.y2 : c.y1;
                for (int i = xa; i <= xb; i++)
                    for (int j = ya; j <= yb; j++)
                        if (c.fill || i == xa || i == xb || j == ya || j == yb)
                            m_flag[pix(i, j)] = 1'b1;
                push_ack(1'b0);
            end
            FUNC_CLEAR: begin
                for (int k = 0; k < SIDE*SIDE; k++) begin
                    m_flag[k] = 1'b0;
                    m_level[k] = LEVEL_FULL;
                end
                push_ack(1'b0);
            end
            default: begin
                hi = m_ceil;
                lo = m_floor;
                if (hi == 0 || hi > 100) hi = 100;
                if (lo >= hi) begin
                    push_ack(1'b1);
                end else begin
                    scale = (hi - lo) * m_global + lo * 100;
                    for (int i = 0; i < SIDE; i++) begin
                        w.word = COL_PIN[i];
                        for (int j = 0; j < SIDE; j++) begin
                            case (m_rot)
                                2'd1: begin sc = j; sr = SIDE-1-i; end
                                2'd2: begin sc = SIDE-1-i; sr = SIDE-1-j; end
                                2'd3: begin sc = SIDE-1-j; sr = i; end
                                default: begin sc = i; sr = j; end
                            endcase
                            p = pix(sc, sr);
                            duty = 0;
                            if (m_global != 0 && m_level[p] != 0)
                                duty = (m_level[p] * scale) / 10000;
                            if (!(m_flag[p] && m_phase < duty))
                                w.word |= ROW_PIN[j];
                        end
                        w.col = XY_W'(i);
                        w.last = (i == SIDE-1);
                        w.status = 1'b0;
                        expected_cols.push_back(w);
                    end
                    m_phase = (m_phase >= PHASE_MAX) ? '0 : m_phase + 1'b1;
                end
            end
        endcase
    endtask

    // Driver: command words from the queue; a word is held until it is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 23)) begin
                t_cmd_word c;
                c = pending_cmds.pop_front();
                i_in_valid <= 1'b1;
                {i_func, i_x_first, i_y_first, i_x_second, i_y_second, i_fill,
                 i_pixel_on, i_pixel_level} <= c;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 23);
    end

    // Monitor: predict on accept, check on result
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire)
            predict_scan({i_func, i_x_first, i_y_first, i_x_second, i_y_second, i_fill,
                          i_pixel_on, i_pixel_level});
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cols.size() == 0) begin
                $display("%0t: unexpected word %h col %0d", $time, o_column_word,
                         o_column_index);
                errors++;
            end else begin
                t_col_word e;
                e = expected_cols.pop_front();
                if (e.word !== o_column_word) begin
                    $display("%0t: column_word exp %h got %h", $time, e.word, o_column_word);
                    errors++;
                end
                if (e.col !== o_column_index) begin
                    $display("%0t: column_index exp %0d got %0d", $time, e.col,
                             o_column_index);
                    errors++;
                end
                if (e.last !== o_last) begin
                    $display("%0t: last exp %b got %b", $time, e.last, o_last);
                    errors++;
                end
                if (e.status !== o_status) begin
                    $display("%0t: status exp %b got %b", $time, e.status, o_status);
                    errors++;
                end
            end
        end
    end

    function automatic t_cmd_word mk(t_func f, logic [XY_W-1:0] x1, logic [XY_W-1:0] y1,
                                     logic [XY_W-1:0] x2, logic [XY_W-1:0] y2,
                                     bit fl, bit on, logic [LEVEL_W-1:0] lvl);
        t_cmd_word c;
        c.func = f; c.x1 = x1; c.y1 = y1; c.x2 = x2; c.y2 = y2;
        c.fill = fl; c.on = on; c.lvl = lvl;
        return c;
    endfunction

    function automatic t_cmd_word rand_cmd(int refresh_pct);
        t_cmd_word c;
        c = t_cmd_word'($urandom);
        if ($urandom_range(99) < refresh_pct) c.func = FUNC_REFRESH;
        else if (c.func == FUNC_REFRESH || (c.func == FUNC_CLEAR && $urandom_range(3) != 0))
            c.func = FUNC_SET;
        if ($urandom_range(3) != 0) c.lvl = LEVEL_W'($urandom_range(100));
        if (c.func == FUNC_RECT && $urandom_range(2) != 0) begin
            c.x2 = c.x1 + XY_W'($urandom_range(3));
            c.y2 = c.y1 + XY_W'($urandom_range(3));
            if (c.x2 < c.x1) c.x2 = 15;
            if (c.y2 < c.y1) c.y2 = 15;
        end
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || i_in_valid || expected_cols.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ROTATION: m_rot = val[1:0];
            CFG_GLOBAL:   m_global = val & 8'h7f;
            CFG_FLOOR:    m_floor = val & 8'h7f;
            default:      m_ceil = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [1:0] r, logic [7:0] g, logic [7:0] f, logic [7:0] c);
        write_reg(CFG_ROTATION, {6'd0, r});
        write_reg(CFG_GLOBAL, g);
        write_reg(CFG_FLOOR, f);
        write_reg(CFG_CEILING, c);
    endtask

    initial begin
        m_rot = 0; m_global = 100; m_floor = 0; m_ceil = 0; m_phase = 0;
        for (int k = 0; k < SIDE*SIDE; k++) begin
            m_flag[k] = 1'b0;
            m_level[k] = LEVEL_FULL;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, extreme levels, reversed rectangles, bad limits
        pending_cmds.push_back(mk(FUNC_SET, 0, 0, 0, 0, 1, 1, 100));
        pending_cmds.push_back(mk(FUNC_SET, 15, 15, 15, 15, 1, 1, 127));
        pending_cmds.push_back(mk(FUNC_SET, 15, 0, 0, 15, 0, 1, 0));
        pending_cmds.push_back(mk(FUNC_SET, 0, 15, 15, 0, 1, 1, 1));
        pending_cmds.push_back(mk(FUNC_RECT, 12, 10, 3, 2, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_RECT, 1, 14, 6, 8, 1, 1, 127));
        pending_cmds.push_back(mk(FUNC_RECT, 7, 7, 7, 7, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_REFRESH, 15, 15, 15, 15, 1, 1, 127));
        pending_cmds.push_back(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_RECT, 0, 0, 15, 15, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        set_regs(1, 0, 0, 0);
        pending_cmds.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        set_regs(3, 100, 50, 50);     // floor equals ceiling: error
        pending_cmds.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        set_regs(2, 127, 100, 0);     // floor 100 against ceiling read as 100
        pending_cmds.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        set_regs(2, 60, 127, 255);
        pending_cmds.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Random phases with varied settings; phase 2 runs with no idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) set_regs(2'($urandom_range(3)), 255, 255, 255);
            else set_regs(2'($urandom_range(3)), 8'($urandom_range(100)),
                          8'($urandom_range(60)), 8'($urandom_range(255)));
            quiet = (ph == 2);
            for (int n = 0; n < 52; n++) pending_cmds.push_back(rand_cmd(12));
            wait_drained();
        end
        quiet = 0;
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
